// ===== sv/bba_pkg.sv =====
// Shared types and constants of the buddy block allocator.
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

   localparam int HEAP_LOG   = 10;
   localparam int IDX_W      = HEAP_LOG + 1;
   localparam int NODE_COUNT = 1 << IDX_W;
   localparam int CLR_W      = IDX_W + 1;

   typedef enum logic [1:0] {
      NODE_ABSENT = 2'd0,
      NODE_FREE   = 2'd1,
      NODE_ALLOC  = 2'd2,
      NODE_SPLIT  = 2'd3
   } node_state_type;

   typedef enum logic [1:0] {
      OP_ALLOC    = 2'd0,
      OP_FREE     = 2'd1,
      OP_COLLAPSE = 2'd2,
      OP_NONE     = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_SPACE = 2'd1,
      STATUS_BAD_FREE = 2'd2,
      STATUS_UNUSED   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_LEFT,
      IDX_NEXT,
      IDX_UP,
      IDX_FREE
   } idx_op_type;

   typedef enum logic [1:0] {
      ADDR_SELF,
      ADDR_LEFT,
      ADDR_RIGHT
   } addr_sel_type;

   typedef struct packed {
      logic           load;
      idx_op_type     idx_op;
      logic           rd_en;
      addr_sel_type   rd_sel;
      logic           wr_en;
      addr_sel_type   wr_sel;
      node_state_type wr_data;
      logic           clr_step;
      logic           keep_left;
      logic           set_res;
      status_type     res_status;
      logic           res_alloc;
      logic           res_load;
   } cmd_type;

   typedef struct packed {
      opcode_type     opcode;
      node_state_type rd_state;
      logic           left_free;
      logic           is_root;
      logic           is_odd;
      logic           at_leaf;
      logic           log_eq;
      logic           want_too_big;
      logic           free_ok;
      logic           clr_done;
      logic           out_busy;
   } stat_type;

endpackage
`default_nettype wire

// ===== sv/bba_req_if.sv =====
// Request channel of the buddy block allocator.
`timescale 1ns / 1ps
`default_nettype none
interface bba_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] request_size;
   logic [9:0]  free_offset;
   logic [3:0]  free_size_log;

   modport source (output valid, opcode, request_size, free_offset, free_size_log,
                   input ready);
   modport sink   (input valid, opcode, request_size, free_offset, free_size_log,
                   output ready);
endinterface
`default_nettype wire

// ===== sv/bba_rsp_if.sv =====
// Response channel of the buddy block allocator.
`timescale 1ns / 1ps
`default_nettype none
interface bba_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [9:0] block_offset;
   logic [3:0] block_size_log;

   modport source (output valid, status, block_offset, block_size_log, input ready);
   modport sink   (input valid, status, block_offset, block_size_log, output ready);
endinterface
`default_nettype wire

// ===== sv/bba_dp.sv =====
// Datapath: node store, walk index, item fields and result registers.
`timescale 1ns / 1ps
`default_nettype none
module bba_dp (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire bba_pkg::cmd_type cmd,
   output bba_pkg::stat_type    stat,
   bba_req_if.sink              req_chan,
   bba_rsp_if.source            rsp_chan
);

   // Bit length of (req - 1), i.e. ceil(log2(req)) with zero taken as one
   function automatic logic [4:0] want_of(input logic [15:0] req);
      logic [15:0] r;
      logic [4:0]  n;
      r = (req == 16'd0) ? 16'd0 : req - 16'd1;
      n = 5'd0;
      for (int i = 0; i < 16; i++) begin
         if (r[i]) n = 5'(i + 1);
      end
      return n;
   endfunction

   logic [1:0]  mem [0:bba_pkg::NODE_COUNT-1];

   logic [bba_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [3:0]                depth_ff, depth_in;
   logic [4:0]                want_ff;
   bba_pkg::opcode_type       opcode_ff;
   logic [9:0]                foff_ff;
   logic [3:0]                flog_ff;
   bba_pkg::node_state_type   rd_state_ff;
   logic                      lfree_ff;
   logic [bba_pkg::CLR_W-1:0] clr_cnt_ff;
   bba_pkg::status_type       pend_status_ff;
   logic [9:0]                pend_off_ff;
   logic [3:0]                pend_log_ff;
   logic                      rsp_valid_ff;
   bba_pkg::status_type       rsp_status_ff;
   logic [9:0]                rsp_off_ff;
   logic [3:0]                rsp_log_ff;

   logic [bba_pkg::IDX_W-1:0] left_idx, right_idx, rd_addr, wr_addr;
   logic [9:0]                free_mask;
   logic [3:0]                node_log;
   logic [20:0]               off_wide;

   assign left_idx  = {idx_ff[bba_pkg::IDX_W-2:0], 1'b0};
   assign right_idx = {idx_ff[bba_pkg::IDX_W-2:0], 1'b1};
   assign free_mask = ~(10'h3FF << flog_ff);
   assign node_log  = 4'(bba_pkg::HEAP_LOG) - depth_ff;
   assign off_wide  = {10'd0, idx_ff} << want_ff[3:0];

   always_comb begin
      unique case (cmd.rd_sel)
         bba_pkg::ADDR_LEFT:  rd_addr = left_idx;
         bba_pkg::ADDR_RIGHT: rd_addr = right_idx;
         default:             rd_addr = idx_ff;
      endcase
      unique case (cmd.wr_sel)
         bba_pkg::ADDR_LEFT:  wr_addr = left_idx;
         bba_pkg::ADDR_RIGHT: wr_addr = right_idx;
         default:             wr_addr = idx_ff;
      endcase
   end

   // Walk index update
   always_comb begin
      idx_in   = idx_ff;
      depth_in = depth_ff;
      if (cmd.load) begin
         idx_in   = bba_pkg::IDX_W'(1);
         depth_in = 4'd0;
      end else begin
         unique case (cmd.idx_op)
            bba_pkg::IDX_LEFT: begin
               idx_in   = left_idx;
               depth_in = depth_ff + 4'd1;
            end
            bba_pkg::IDX_NEXT: idx_in = idx_ff + bba_pkg::IDX_W'(1);
            bba_pkg::IDX_UP: begin
               idx_in   = idx_ff >> 1;
               depth_in = depth_ff - 4'd1;
            end
            bba_pkg::IDX_FREE: idx_in = {1'b1, foff_ff} >> flog_ff;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      depth_ff <= depth_in;
      if (cmd.load) begin
         want_ff   <= want_of(req_chan.request_size);
         opcode_ff <= bba_pkg::opcode_type'(req_chan.opcode);
         foff_ff   <= req_chan.free_offset;
         flog_ff   <= req_chan.free_size_log;
      end
      if (cmd.keep_left) lfree_ff <= (rd_state_ff == bba_pkg::NODE_FREE);
      if (cmd.set_res) begin
         pend_status_ff <= cmd.res_status;
         pend_off_ff    <= cmd.res_alloc ? off_wide[9:0] : 10'd0;
         pend_log_ff    <= cmd.res_alloc ? want_ff[3:0] : 4'd0;
      end
      if (cmd.res_load) begin
         rsp_status_ff <= pend_status_ff;
         rsp_off_ff    <= pend_off_ff;
         rsp_log_ff    <= pend_log_ff;
      end
   end

   // Node store: clearing sweep or single write, registered read
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         mem[clr_cnt_ff[bba_pkg::IDX_W-1:0]] <=
            (clr_cnt_ff == bba_pkg::CLR_W'(1)) ? bba_pkg::NODE_FREE : bba_pkg::NODE_ABSENT;
      end else if (cmd.wr_en) begin
         mem[wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) rd_state_ff <= bba_pkg::node_state_type'(mem[rd_addr]);
   end

   // Clear counter and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) clr_cnt_ff <= clr_cnt_ff + bba_pkg::CLR_W'(1);
         if (cmd.res_load)
            rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.block_offset   = rsp_off_ff;
   assign rsp_chan.block_size_log = rsp_log_ff;

   assign stat.opcode       = opcode_ff;
   assign stat.rd_state     = rd_state_ff;
   assign stat.left_free    = lfree_ff;
   assign stat.is_root      = (idx_ff == bba_pkg::IDX_W'(1));
   assign stat.is_odd       = idx_ff[0];
   assign stat.at_leaf      = idx_ff[bba_pkg::IDX_W-1];
   assign stat.log_eq       = ({1'b0, node_log} == want_ff);
   assign stat.want_too_big = (want_ff > 5'(bba_pkg::HEAP_LOG));
   assign stat.free_ok      = (flog_ff <= 4'(bba_pkg::HEAP_LOG)) &&
                              ((foff_ff & free_mask) == 10'd0);
   assign stat.clr_done     = clr_cnt_ff[bba_pkg::CLR_W-1];
   assign stat.out_busy     = rsp_valid_ff && !rsp_chan.ready;

endmodule
`default_nettype wire

// ===== sv/bba_ctrl.sv =====
// Controller: sequences the clearing sweep, tree walks and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module bba_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire bba_pkg::stat_type stat,
   output bba_pkg::cmd_type      cmd
);

   typedef enum logic [18:0] {
      S_CLEAR  = 19'h00001,
      S_IDLE   = 19'h00002,
      S_DECODE = 19'h00004,
      S_A_READ = 19'h00008,
      S_A_EVAL = 19'h00010,
      S_A_SPL1 = 19'h00020,
      S_A_SPL2 = 19'h00040,
      S_A_FAIL = 19'h00080,
      S_F_READ = 19'h00100,
      S_F_EVAL = 19'h00200,
      S_C_READ = 19'h00400,
      S_C_EVAL = 19'h00800,
      S_C_DONE = 19'h01000,
      S_C_RDL  = 19'h02000,
      S_C_RDR  = 19'h04000,
      S_C_EVP  = 19'h08000,
      S_C_W1   = 19'h10000,
      S_C_W2   = 19'h20000,
      S_DONE   = 19'h40000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

   // Next state and datapath commands
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.idx_op     = bba_pkg::IDX_HOLD;
      cmd.rd_sel     = bba_pkg::ADDR_SELF;
      cmd.wr_sel     = bba_pkg::ADDR_SELF;
      cmd.wr_data    = bba_pkg::NODE_ABSENT;
      cmd.res_status = bba_pkg::STATUS_OK;
      req_ready      = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            if (stat.clr_done) state_in = S_IDLE;
            else               cmd.clr_step = 1'b1;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.opcode)
               bba_pkg::OP_ALLOC: begin
                  if (stat.want_too_big) begin
                     cmd.set_res    = 1'b1;
                     cmd.res_status = bba_pkg::STATUS_NO_SPACE;
                     state_in       = S_DONE;
                  end else begin
                     state_in = S_A_READ;
                  end
               end
               bba_pkg::OP_FREE: begin
                  if (stat.free_ok) begin
                     cmd.idx_op = bba_pkg::IDX_FREE;
                     state_in   = S_F_READ;
                  end else begin
                     cmd.set_res    = 1'b1;
                     cmd.res_status = bba_pkg::STATUS_BAD_FREE;
                     state_in       = S_DONE;
                  end
               end
               bba_pkg::OP_COLLAPSE: state_in = S_C_READ;
               default: begin
                  cmd.set_res = 1'b1;
                  state_in    = S_DONE;
               end
            endcase
         end
         S_A_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_A_EVAL;
         end
         S_A_EVAL: begin
            if (stat.log_eq) begin
               if (stat.rd_state == bba_pkg::NODE_FREE) begin
                  cmd.wr_en     = 1'b1;
                  cmd.wr_data   = bba_pkg::NODE_ALLOC;
                  cmd.set_res   = 1'b1;
                  cmd.res_alloc = 1'b1;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_A_FAIL;
               end
            end else if (stat.rd_state == bba_pkg::NODE_FREE) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_data = bba_pkg::NODE_SPLIT;
               state_in    = S_A_SPL1;
            end else if (stat.rd_state == bba_pkg::NODE_SPLIT) begin
               cmd.idx_op = bba_pkg::IDX_LEFT;
               state_in   = S_A_READ;
            end else begin
               state_in = S_A_FAIL;
            end
         end
         S_A_SPL1: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = bba_pkg::ADDR_LEFT;
            cmd.wr_data = bba_pkg::NODE_FREE;
            state_in    = S_A_SPL2;
         end
         S_A_SPL2: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = bba_pkg::ADDR_RIGHT;
            cmd.wr_data = bba_pkg::NODE_FREE;
            cmd.idx_op  = bba_pkg::IDX_LEFT;
            state_in    = S_A_READ;
         end
         // Back off: try the right sibling, or climb while on a right child
         S_A_FAIL: begin
            if (stat.is_root) begin
               cmd.set_res    = 1'b1;
               cmd.res_status = bba_pkg::STATUS_NO_SPACE;
               state_in       = S_DONE;
            end else if (!stat.is_odd) begin
               cmd.idx_op = bba_pkg::IDX_NEXT;
               state_in   = S_A_READ;
            end else begin
               cmd.idx_op = bba_pkg::IDX_UP;
            end
         end
         S_F_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_F_EVAL;
         end
         S_F_EVAL: begin
            cmd.set_res = 1'b1;
            if (stat.rd_state == bba_pkg::NODE_ALLOC) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_data = bba_pkg::NODE_FREE;
            end else begin
               cmd.res_status = bba_pkg::STATUS_BAD_FREE;
            end
            state_in = S_DONE;
         end
         S_C_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_C_EVAL;
         end
         S_C_EVAL: begin
            if (stat.rd_state == bba_pkg::NODE_SPLIT && !stat.at_leaf) begin
               cmd.idx_op = bba_pkg::IDX_LEFT;
               state_in   = S_C_READ;
            end else begin
               state_in = S_C_DONE;
            end
         end
         // Subtree finished: go to the sibling or post-process the parent
         S_C_DONE: begin
            if (stat.is_root) begin
               cmd.set_res = 1'b1;
               state_in    = S_DONE;
            end else if (!stat.is_odd) begin
               cmd.idx_op = bba_pkg::IDX_NEXT;
               state_in   = S_C_READ;
            end else begin
               cmd.idx_op = bba_pkg::IDX_UP;
               state_in   = S_C_RDL;
            end
         end
         S_C_RDL: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = bba_pkg::ADDR_LEFT;
            state_in   = S_C_RDR;
         end
         S_C_RDR: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = bba_pkg::ADDR_RIGHT;
            cmd.keep_left = 1'b1;
            state_in      = S_C_EVP;
         end
         S_C_EVP: begin
            if (stat.left_free && stat.rd_state == bba_pkg::NODE_FREE) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_data = bba_pkg::NODE_FREE;
               state_in    = S_C_W1;
            end else begin
               state_in = S_C_DONE;
            end
         end
         S_C_W1: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = bba_pkg::ADDR_LEFT;
            state_in   = S_C_W2;
         end
         S_C_W2: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = bba_pkg::ADDR_RIGHT;
            state_in   = S_C_DONE;
         end
         S_DONE: begin
            if (!stat.out_busy) begin
               cmd.res_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

endmodule
`default_nettype wire

// ===== sv/buddy_block_allocator.sv =====
// Top level of the buddy block allocator.
// A 1024-byte heap is kept as a tree of 2047 two-bit node states in a memory
// that is read or written one node at a time. After reset the block sweeps the
// memory and takes no request until the sweep is done. One request is handled at
// a time, and every item passes through an idle, a decode and a hand-off state
// around its walk. A free adds a read and an evaluate state. An allocate reads and
// evaluates each node on its depth-first walk, writes each split node and its two
// children, and takes a back-off step for each node rejected and each level climbed
// back. A collapse reads, evaluates and finishes each node entered, reads both
// children of each parent it climbs back to, and merges the pair where both are free.
// The response sits in an output register, so a new request is taken while it
// waits; the next result is held in the hand-off state until that register is empty.
`timescale 1ns / 1ps
`default_nettype none
module buddy_block_allocator (
   input  wire logic clock,
   input  wire logic reset,
   bba_req_if.sink   req_chan,
   bba_rsp_if.source rsp_chan
);

   bba_pkg::cmd_type  cmd;
   bba_pkg::stat_type stat;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bba_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire
